/* rtl/core/hsa_pkg.sv */
// Shared types and codes for the handle slot allocator.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package hsa_pkg;

    // operation carried by an input item
    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_PLACE   = 2'd1,
        KIND_LOOKUP  = 2'd2,
        KIND_RELEASE = 2'd3
    } t_kind;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BAD  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // field widths fixed by the item format
    localparam int unsigned IDX_BITS = 7;
    localparam int unsigned OBJ_BITS = 32;

    // control sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // slot table port control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_slot_ctl;

    // free stack control
    typedef struct packed {
        logic rd_en;
        logic pop;
        logic push;
    } t_stk_ctl;

endpackage

`default_nettype wire

/* rtl/core/handle_slot_allocator.sv */
// Handle slot allocator top level: item sequencer, bump pointer, result register.
// Depends on hsa_pkg, hsa_slot_mem and hsa_free_stack.
//
//  channel | valid   | stall   | fields
//  --------+---------+---------+------------------------------------------
//  input   | i_valid | o_stall | i_kind, i_slot_index, i_object_value
//  output  | o_valid | i_stall | o_status, o_granted_index, o_read_value
//
// An item is accepted in ST_IDLE, which reads the slot table and the stack top;
// ST_EXEC decides and writes back, and only then can the next item be taken.
// After reset a clearing pass zeroes the slot table with o_stall held high.
// A result waits in the output register while the next item is taken; the
// write-back in ST_EXEC holds while that register is full and i_stall is high.
`default_nettype none

module handle_slot_allocator #(
    parameter int unsigned CAPACITY   = 128,
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [6:0]  i_slot_index,
    input  wire logic [31:0] i_object_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [6:0]       o_granted_index,
    output logic [31:0]      o_read_value
);

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XB = hsa_pkg::IDX_BITS;
    localparam int unsigned OB = hsa_pkg::OBJ_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [31:0]   CAP_W = 32'(CAPACITY);

    hsa_pkg::t_state    r_state, n_state;
    hsa_pkg::t_kind     r_kind;
    logic [XB-1:0]      r_idx;
    logic [VALUE_BITS-1:0] r_val;
    logic [CW-1:0]      r_next_unused, n_next_unused;

    logic               r_out_valid;
    logic [1:0]         r_status, n_status;
    logic [XB-1:0]      r_granted, n_granted;
    logic [OB-1:0]      r_read_value, n_read_value;

    hsa_pkg::t_slot_ctl slot_ctl;
    hsa_pkg::t_stk_ctl  stk_ctl;
    logic [IW-1:0]      slot_rd_addr;
    logic [IW-1:0]      slot_wr_addr;
    logic [VALUE_BITS-1:0] slot_wr_data;
    logic [VALUE_BITS-1:0] slot_q;
    logic               clearing;
    logic [IW-1:0]      stk_top;
    logic               stk_empty;
    logic               stk_full;

    logic               accept;
    logic               retire;
    logic               out_free;
    logic               in_idx_ok;
    logic               r_idx_ok;
    logic [IW+XB-1:0]   in_idx_ext;
    logic [IW+XB-1:0]   r_idx_ext;
    logic [VALUE_BITS+OB-1:0] in_val_ext;
    logic [VALUE_BITS+OB-1:0] rd_val_ext;
    logic [IW+XB-1:0]   pick_ext;
    logic [IW-1:0]      pick;
    logic               occupied;

    hsa_slot_mem #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .IW         (IW)
    ) u_slot_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (slot_ctl),
        .i_rd_addr  (slot_rd_addr),
        .i_wr_addr  (slot_wr_addr),
        .i_wr_data  (slot_wr_data),
        .o_rd_data  (slot_q),
        .o_clearing (clearing)
    );

    hsa_free_stack #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_free_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (stk_ctl),
        .i_push_data (r_idx_ext[IW-1:0]),
        .o_top       (stk_top),
        .o_empty     (stk_empty),
        .o_full      (stk_full)
    );

    // input handshake and range checks
    always_comb begin
        o_stall    = (r_state != hsa_pkg::ST_IDLE) || clearing;
        accept     = i_valid && !o_stall;
        out_free   = !r_out_valid || !i_stall;
        retire     = (r_state == hsa_pkg::ST_EXEC) && out_free;
        in_idx_ok  = {25'd0, i_slot_index} < CAP_W;
        r_idx_ok   = {25'd0, r_idx} < CAP_W;
        in_idx_ext = {{IW{1'b0}}, i_slot_index};
        r_idx_ext  = {{IW{1'b0}}, r_idx};
        in_val_ext = {{VALUE_BITS{1'b0}}, i_object_value};
        rd_val_ext = {{OB{1'b0}}, slot_q};
        occupied   = (slot_q != '0);
    end

    // slot read address, issued in the accept cycle
    always_comb begin
        slot_rd_addr = in_idx_ok ? in_idx_ext[IW-1:0] : '0;
    end

    // item registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= hsa_pkg::t_kind'(i_kind);
            r_idx  <= i_slot_index;
            r_val  <= in_val_ext[VALUE_BITS-1:0];
        end
    end

    // reads in the accept cycle, decide and write back in ST_EXEC
    always_comb begin
        n_status       = hsa_pkg::STAT_OK;
        n_granted      = '0;
        n_read_value   = '0;
        n_next_unused  = r_next_unused;
        slot_ctl.rd_en = accept;
        slot_ctl.wr_en = 1'b0;
        slot_wr_addr   = r_idx_ext[IW-1:0];
        slot_wr_data   = r_val;
        stk_ctl.rd_en  = accept;
        stk_ctl.pop    = 1'b0;
        stk_ctl.push   = 1'b0;
        pick           = stk_top;

        unique case (r_kind)
            hsa_pkg::KIND_ALLOC: begin
                if (!stk_empty) begin
                    pick        = stk_top;
                    stk_ctl.pop = retire;
                end else if (r_next_unused < CAP_C) begin
                    pick          = r_next_unused[IW-1:0];
                    n_next_unused = r_next_unused + 1'b1;
                end else begin
                    n_status = hsa_pkg::STAT_FULL;
                end
                if (n_status == hsa_pkg::STAT_OK) begin
                    slot_ctl.wr_en = retire;
                    slot_wr_addr   = pick;
                    n_granted      = pick_ext[XB-1:0];
                end
            end
            hsa_pkg::KIND_PLACE: begin
                if (!r_idx_ok) begin
                    n_status = hsa_pkg::STAT_FULL;
                end else if (occupied) begin
                    n_status = hsa_pkg::STAT_BAD;
                end else begin
                    slot_ctl.wr_en = retire;
                end
            end
            hsa_pkg::KIND_LOOKUP: begin
                if (!r_idx_ok || !occupied) begin
                    n_status = hsa_pkg::STAT_BAD;
                end else begin
                    n_read_value = rd_val_ext[OB-1:0];
                end
            end
            hsa_pkg::KIND_RELEASE: begin
                if (!r_idx_ok || !occupied) begin
                    n_status = hsa_pkg::STAT_BAD;
                end else begin
                    slot_ctl.wr_en = retire;
                    slot_wr_data   = '0;
                    stk_ctl.push   = retire && !stk_full;
                end
            end
            default: begin
                n_status = hsa_pkg::STAT_BAD;
            end
        endcase
    end

    assign pick_ext = {{XB{1'b0}}, pick};

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hsa_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = hsa_pkg::ST_EXEC;
                end
            end
            hsa_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = hsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= hsa_pkg::ST_IDLE;
            r_next_unused <= '0;
        end else begin
            r_state <= n_state;
            if (retire) begin
                r_next_unused <= n_next_unused;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (retire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_status     <= n_status;
            r_granted    <= n_granted;
            r_read_value <= n_read_value;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_read_value    = r_read_value;

endmodule

`default_nettype wire

/* rtl/core/hsa_slot_mem.sv */
// Slot value table: one synchronous memory with a registered read port
// and a clearing pass after reset. Uses hsa_pkg for its control struct.
`default_nettype none

module hsa_slot_mem #(
    parameter int unsigned CAPACITY   = 128,
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned IW         = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire hsa_pkg::t_slot_ctl    i_ctl,
    input  wire logic [IW-1:0]         i_rd_addr,
    input  wire logic [IW-1:0]         i_wr_addr,
    input  wire logic [VALUE_BITS-1:0] i_wr_data,
    output logic [VALUE_BITS-1:0]      o_rd_data,
    output logic                       o_clearing
);

    localparam logic [IW-1:0] LAST_ADDR = IW'(CAPACITY - 1);

    logic [VALUE_BITS-1:0] r_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_rd_data;
    logic                  r_clr_busy;
    logic [IW-1:0]         r_clr_addr;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;

    // clearing pass after reset, zeroing one entry at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // the clearing pass owns the write port while it runs
    always_comb begin
        wr_en   = r_clr_busy | i_ctl.wr_en;
        wr_addr = r_clr_busy ? r_clr_addr : i_wr_addr;
        wr_data = r_clr_busy ? '0 : i_wr_data;
    end

    // memory array with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_busy;

endmodule

`default_nettype wire

/* rtl/core/hsa_free_stack.sv */
// LIFO of released slot indexes: memory with registered top read and a count.
// Uses hsa_pkg for its control struct.
`default_nettype none

module hsa_free_stack #(
    parameter int unsigned CAPACITY = 128,
    parameter int unsigned IW       = 7,
    parameter int unsigned CW       = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hsa_pkg::t_stk_ctl  i_ctl,
    input  wire logic [IW-1:0]      i_push_data,
    output logic [IW-1:0]           o_top,
    output logic                    o_empty,
    output logic                    o_full
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [IW-1:0] r_mem [CAPACITY];
    logic [IW-1:0] r_top;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] count_m1;
    logic [IW-1:0] rd_addr;

    // top entry sits one below the count
    always_comb begin
        count_m1 = r_count - 1'b1;
        rd_addr  = (r_count != '0) ? count_m1[IW-1:0] : '0;
        o_empty  = (r_count == '0);
        o_full   = (r_count == CAP_C);
    end

    // count update, push onto a full stack is dropped
    always_comb begin
        n_count = r_count;
        if (i_ctl.pop && !o_empty) begin
            n_count = count_m1;
        end else if (i_ctl.push && !o_full) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // stack memory, written at the count and read at its top
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !o_full) begin
            r_mem[r_count[IW-1:0]] <= i_push_data;
        end
        if (i_ctl.rd_en) begin
            r_top <= r_mem[rd_addr];
        end
    end

    assign o_top = r_top;

endmodule

`default_nettype wire
